[hdl/pfp_pkg.sv]
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants for the frame parser
// Phase codes, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int MAX_HEADERS     = 8;
  localparam int KEY_BYTES       = 63;
  localparam int VALUE_BYTES     = 255;
  localparam int MAX_FRAME_BYTES = 65536;

  typedef enum logic [7:0] {
    OP_TAG       = 8'b0000_0001,
    OP_VALUE     = 8'b0000_0010,
    OP_SKIPVAR   = 8'b0000_0100,
    OP_LEN       = 8'b0000_1000,
    OP_SKIPBYTES = 8'b0001_0000,
    OP_HEADER    = 8'b0010_0000,
    OP_PAYLOAD   = 8'b0100_0000,
    OP_ERROR     = 8'b1000_0000
  } outer_phase_t;

  typedef enum logic [5:0] {
    HP_TAG       = 6'b00_0001,
    HP_LEN       = 6'b00_0010,
    HP_STR       = 6'b00_0100,
    HP_SKIPVAR   = 6'b00_1000,
    HP_SKIPBYTES = 6'b01_0000,
    HP_DEAD      = 6'b10_0000
  } header_phase_t;

  localparam logic [3:0] K_SEQ     = 4'd0;
  localparam logic [3:0] K_KEY     = 4'd4;
  localparam logic [3:0] K_VAL     = 4'd5;
  localparam logic [3:0] K_HDR_END = 4'd6;
  localparam logic [3:0] K_PAYLOAD = 4'd7;
  localparam logic [3:0] K_DONE    = 4'd8;
  localparam logic [3:0] K_ERROR   = 4'd9;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_TRUNC = 2'd1;
  localparam logic [1:0] E_WIRE  = 2'd2;
  localparam logic [1:0] E_LONG  = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [2:0]  header_index;
    logic [15:0] offset;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic [1:0]  count;
    result_t     r0;
    result_t     r1;
    result_t     r2;
  } result_set_t;

endpackage

[hdl/protobuf_frame_parser.sv]
// ----------------------------------------------------------------------------
// protobuf_frame_parser: streaming protobuf wire format decoder
// Decodes one frame byte per cycle into seq/log/service/method, header
// key/value bytes, payload bytes and a final done or error event.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per request; in_tlast marks the frame's last byte.
//   out_* : result events, out_tlast on the last event caused by a byte.
//   Each accepted byte updates the parser state in that same cycle and
//   yields zero to three events, written into a small result queue.
//   Events are registered in the queue, reaching out_* after those ahead.
//   Throughput: one byte per cycle while in_tready is high; the parser state
//   update is a single registered step; the queue drains one event per cycle.
//   Bytes yielding up to three events can outrun the drain; in_tready drops
//   while the queue has fewer than three free slots.
//   A receiver stall holds the queue head; in_tready falls once it fills.
//   Reset (rst_n low, synchronous) empties the queue and returns the parser
//   to expecting a field tag with no latched error.
//   After a last byte the parser clears itself for the next frame.
// ----------------------------------------------------------------------------
module protobuf_frame_parser import pfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [63:0] value, [66:64] header_index,
                                  // [82:67] offset, [84:83] error_code, pad
  output logic [3:0]  out_tuser,  // kind
  output logic        out_tlast   // last
);

  outer_phase_t  op_r, op_nxt;
  header_phase_t hp_r, hp_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  sh_r, sh_nxt;
  logic [31:0] fn_r, fn_nxt;
  logic [2:0]  wk_r, wk_nxt;
  logic [31:0] orem_r, orem_nxt;
  logic [31:0] hrem_r, hrem_nxt;
  logic [31:0] hf_r, hf_nxt;
  logic [31:0] srem_r, srem_nxt;
  logic [15:0] spos_r, spos_nxt;
  logic [15:0] hseen_r, hseen_nxt;
  logic [15:0] ppos_r, ppos_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        accept, space;
  result_set_t rs;
  result_t     out_res;

  // varint step on the current byte
  logic [63:0] vacc;
  logic [5:0]  vsh;
  logic        vdone, vlong;
  logic [63:0] v;
  logic [31:0] hrem_dec;
  logic [7:0]  b;

  assign b      = in_tdata;
  assign accept = in_tvalid && in_tready;
  assign in_tready = space;

  always_comb begin
    vsh   = (sh_r <= 4'd9) ? 6'(7 * sh_r) : 6'd63;
    vacc  = acc_r | ({57'd0, b[6:0]} << vsh);
    vdone = !b[7];
    vlong = b[7] && (sh_r + 4'd1 >= 4'd10);
    v     = vacc;
  end

  function automatic result_t mk(logic [3:0] k, logic [63:0] val, logic [2:0] idx,
                                 logic [15:0] off, logic [1:0] e);
    result_t r;
    r.kind = k; r.value = val; r.header_index = idx; r.offset = off; r.error_code = e;
    return r;
  endfunction

  always_comb begin
    result_t ev [3];
    logic [1:0] n;
    logic hdone;
    op_nxt = op_r; hp_nxt = hp_r; acc_nxt = acc_r; sh_nxt = sh_r;
    fn_nxt = fn_r; wk_nxt = wk_r; orem_nxt = orem_r; hrem_nxt = hrem_r;
    hf_nxt = hf_r; srem_nxt = srem_r; spos_nxt = spos_r; hseen_nxt = hseen_r;
    ppos_nxt = ppos_r; err_nxt = err_r;
    ev[0] = '0; ev[1] = '0; ev[2] = '0; n = 2'd0; hdone = 1'b0;
    hrem_dec = hrem_r - 32'd1;

    // varint-using phases share accumulator update
    if (op_r == OP_TAG || op_r == OP_VALUE || op_r == OP_SKIPVAR || op_r == OP_LEN ||
        (op_r == OP_HEADER && hrem_r != 32'd0 &&
         (hp_r == HP_TAG || hp_r == HP_LEN || hp_r == HP_SKIPVAR))) begin
      if (vdone || vlong) begin
        acc_nxt = '0; sh_nxt = '0;
      end else begin
        acc_nxt = vacc; sh_nxt = sh_r + 4'd1;
      end
    end

    unique case (op_r)
      OP_TAG: begin
        if (vlong) begin
          if (err_r == E_NONE) err_nxt = E_LONG;
          op_nxt = OP_ERROR;
        end else if (vdone) begin
          fn_nxt = v[34:3]; wk_nxt = v[2:0];
          if (v[34:3] >= 32'd1 && v[34:3] <= 32'd4 && v[2:0] == 3'd0) op_nxt = OP_VALUE;
          else if (v[2:0] == 3'd0) op_nxt = OP_SKIPVAR;
          else if (v[2:0] == 3'd2) op_nxt = OP_LEN;
          else if (v[2:0] == 3'd1 || v[2:0] == 3'd5) begin
            orem_nxt = (v[2:0] == 3'd1) ? 32'd8 : 32'd4;
            op_nxt = OP_SKIPBYTES;
          end else begin
            if (err_r == E_NONE) err_nxt = E_WIRE;
            op_nxt = OP_ERROR;
          end
        end
      end
      OP_VALUE: begin
        if (vlong) begin
          if (err_r == E_NONE) err_nxt = E_LONG;
          op_nxt = OP_ERROR;
        end else if (vdone) begin
          ev[0] = mk(K_SEQ + {2'd0, fn_r[1:0] - 2'd1},
                     (fn_r >= 32'd3) ? {32'd0, v[31:0]} : v, 3'd0, 16'd0, E_NONE);
          n = 2'd1;
          op_nxt = OP_TAG;
        end
      end
      OP_SKIPVAR: begin
        if (vlong) begin
          if (err_r == E_NONE) err_nxt = E_LONG;
          op_nxt = OP_ERROR;
        end else if (vdone) op_nxt = OP_TAG;
      end
      OP_LEN: begin
        if (vlong) begin
          if (err_r == E_NONE) err_nxt = E_LONG;
          op_nxt = OP_ERROR;
        end else if (vdone) begin
          if (v > 64'(MAX_FRAME_BYTES)) begin
            if (err_r == E_NONE) err_nxt = E_TRUNC;
            op_nxt = OP_ERROR;
          end else if (fn_r == 32'd5 && hseen_r < 16'(MAX_HEADERS)) begin
            hp_nxt = HP_TAG;
            if (v == 64'd0) hdone = 1'b1;
            else begin
              hrem_nxt = v[31:0]; op_nxt = OP_HEADER;
            end
          end else if (v == 64'd0) op_nxt = OP_TAG;
          else begin
            orem_nxt = v[31:0];
            if (fn_r == 32'd8) begin
              ppos_nxt = '0; op_nxt = OP_PAYLOAD;
            end else op_nxt = OP_SKIPBYTES;
          end
        end
      end
      OP_SKIPBYTES: begin
        if (orem_r > 32'd1) orem_nxt = orem_r - 32'd1;
        else begin
          orem_nxt = '0; op_nxt = OP_TAG;
        end
      end
      OP_PAYLOAD: begin
        ev[0] = mk(K_PAYLOAD, {56'd0, b}, 3'd0, ppos_r, E_NONE);
        n = 2'd1;
        if (ppos_r != 16'hFFFF) ppos_nxt = ppos_r + 16'd1;
        if (orem_r > 32'd1) orem_nxt = orem_r - 32'd1;
        else begin
          orem_nxt = '0; op_nxt = OP_TAG;
        end
      end
      OP_HEADER: begin
        if (hrem_r == 32'd0) hdone = 1'b1;
        else begin
          hrem_nxt = hrem_dec;
          unique case (hp_r)
            HP_TAG: begin
              if (vlong) hp_nxt = HP_DEAD;
              else if (vdone) begin
                hf_nxt = v[34:3]; wk_nxt = v[2:0];
                if (v[2:0] == 3'd2) hp_nxt = HP_LEN;
                else if (v[2:0] == 3'd0) hp_nxt = HP_SKIPVAR;
                else if (v[2:0] == 3'd1 || v[2:0] == 3'd5) begin
                  srem_nxt = (v[2:0] == 3'd1) ? 32'd8 : 32'd4;
                  hp_nxt = (((v[2:0] == 3'd1) ? 32'd8 : 32'd4) > hrem_dec) ?
                           HP_DEAD : HP_SKIPBYTES;
                end else hp_nxt = HP_DEAD;
              end
            end
            HP_LEN: begin
              if (vlong) hp_nxt = HP_DEAD;
              else if (vdone) begin
                if (v > {32'd0, hrem_dec}) hp_nxt = HP_DEAD;
                else begin
                  srem_nxt = v[31:0]; spos_nxt = '0;
                  hp_nxt = (v == 64'd0) ? HP_TAG : HP_STR;
                end
              end
            end
            HP_STR: begin
              if (hf_r == 32'd1 && spos_r < 16'(KEY_BYTES)) begin
                ev[0] = mk(K_KEY, {56'd0, b}, hseen_r[2:0], spos_r, E_NONE); n = 2'd1;
              end else if (hf_r == 32'd2 && spos_r < 16'(VALUE_BYTES)) begin
                ev[0] = mk(K_VAL, {56'd0, b}, hseen_r[2:0], spos_r, E_NONE); n = 2'd1;
              end
              if (spos_r != 16'hFFFF) spos_nxt = spos_r + 16'd1;
              srem_nxt = srem_r - 32'd1;
              if (srem_r == 32'd1) hp_nxt = HP_TAG;
            end
            HP_SKIPVAR: begin
              if (vlong) hp_nxt = HP_DEAD;
              else if (vdone) hp_nxt = HP_TAG;
            end
            HP_SKIPBYTES: begin
              if (srem_r > 32'd1) srem_nxt = srem_r - 32'd1;
              else begin
                srem_nxt = '0; hp_nxt = HP_TAG;
              end
            end
            HP_DEAD: ;
            default: ;
          endcase
          if (hrem_dec == 32'd0) hdone = 1'b1;
        end
      end
      OP_ERROR: ;
      default: ;
    endcase

    if (hdone) begin
      ev[n] = mk(K_HDR_END, 64'd0, hseen_r[2:0], 16'd0, E_NONE);
      n = n + 2'd1;
      if (hseen_r != 16'hFFFF) hseen_nxt = hseen_r + 16'd1;
      op_nxt = OP_TAG; hp_nxt = HP_TAG; acc_nxt = '0; sh_nxt = '0;
    end

    if (in_tlast) begin
      if (err_nxt != E_NONE) ev[n] = mk(K_ERROR, 64'd0, 3'd0, 16'd0, err_nxt);
      else if (op_nxt != OP_TAG || sh_nxt != 4'd0)
        ev[n] = mk(K_ERROR, 64'd0, 3'd0, 16'd0, E_TRUNC);
      else ev[n] = mk(K_DONE, 64'd0, 3'd0, 16'd0, E_NONE);
      n = n + 2'd1;
      op_nxt = OP_TAG; hp_nxt = HP_TAG; acc_nxt = '0; sh_nxt = '0;
      fn_nxt = '0; wk_nxt = '0; orem_nxt = '0; hrem_nxt = '0; hf_nxt = '0;
      srem_nxt = '0; spos_nxt = '0; hseen_nxt = '0; ppos_nxt = '0; err_nxt = E_NONE;
    end

    rs.count = n; rs.r0 = ev[0]; rs.r1 = ev[1]; rs.r2 = ev[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_TAG; hp_r <= HP_TAG; acc_r <= '0; sh_r <= '0; fn_r <= '0;
      wk_r <= '0; orem_r <= '0; hrem_r <= '0; hf_r <= '0; srem_r <= '0;
      spos_r <= '0; hseen_r <= '0; ppos_r <= '0; err_r <= E_NONE;
    end else if (accept) begin
      op_r <= op_nxt; hp_r <= hp_nxt; acc_r <= acc_nxt; sh_r <= sh_nxt;
      fn_r <= fn_nxt; wk_r <= wk_nxt; orem_r <= orem_nxt; hrem_r <= hrem_nxt;
      hf_r <= hf_nxt; srem_r <= srem_nxt; spos_r <= spos_nxt;
      hseen_r <= hseen_nxt; ppos_r <= ppos_nxt; err_r <= err_nxt;
    end
  end

  pfp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .set_in    (rs),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {3'd0, out_res.error_code, out_res.offset,
                      out_res.header_index, out_res.value};

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != E_NONE) |-> (op_r == OP_ERROR)) else $error("error latched outside error phase");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (op_r == OP_TAG && err_r == E_NONE && sh_r == 4'd0))
    else $error("frame end did not clear");
  a_shift: assert property (@(posedge clk) disable iff (!rst_n) sh_r <= 4'd9)
    else $error("varint shift overrun");

endmodule

[hdl/pfp_out_fifo.sv]
// ----------------------------------------------------------------------------
// pfp_out_fifo: result serializer
// Holds up to eight results and presents them one at a time; a new set is
// to be pushed only when it will fit (space); the block does not enforce it.
// ----------------------------------------------------------------------------
module pfp_out_fifo import pfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  result_set_t set_in,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output logic        out_last
);

  result_t    mem_r [8];
  logic [7:0] lst_r;
  logic [2:0] rd_r, wr_r;
  logic [3:0] cnt_r;
  logic       pop;
  logic [3:0] cnt_nxt;

  assign out_valid = cnt_r != 4'd0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rd_r];
  assign out_last  = lst_r[rd_r];
  assign space     = cnt_r <= 4'd5;

  always_comb begin
    cnt_nxt = cnt_r - {3'd0, pop};
    if (push) cnt_nxt = cnt_nxt + {2'd0, set_in.count};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 3'd0; wr_r <= 3'd0; cnt_r <= 4'd0; lst_r <= 8'd0;
    end else begin
      if (pop) rd_r <= rd_r + 3'd1;
      cnt_r <= cnt_nxt;
      if (push) begin
        if (set_in.count >= 2'd1) begin
          mem_r[wr_r] <= set_in.r0; lst_r[wr_r] <= set_in.count == 2'd1;
        end
        if (set_in.count >= 2'd2) begin
          mem_r[wr_r+3'd1] <= set_in.r1; lst_r[wr_r+3'd1] <= set_in.count == 2'd2;
        end
        if (set_in.count == 2'd3) begin
          mem_r[wr_r+3'd2] <= set_in.r2; lst_r[wr_r+3'd2] <= 1'b1;
        end
        wr_r <= wr_r + {1'b0, set_in.count};
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 4'd8)
    else $error("result queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r <= 4'd5) else $error("push without space");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule
